>>> hdl/uart_16550_register_model_unit_defines.svh
// Assertion macros shared by the UART register block.
// Every macro samples on clk and is quiet while arst_n is low.
`ifndef UART_16550_REGISTER_MODEL_UNIT_DEFINES_SVH
`define UART_16550_REGISTER_MODEL_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds on that edge too.
`define U16550_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the following edge.
`define U16550_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/u16550_pkg.sv
// Package for the UART register block: types, register codes and helper functions.
// It depends on nothing else. The step logic and the top level import it.
`timescale 1ns / 1ps
`default_nettype none
package u16550_pkg;

	typedef enum logic [1:0] {
		OP_READ    = 2'd0,
		OP_WRITE   = 2'd1,
		OP_RX      = 2'd2,
		OP_TX_DONE = 2'd3
	} op_t;

	localparam logic [2:0] REG_RBR = 3'd0;
	localparam logic [2:0] REG_IER = 3'd1;
	localparam logic [2:0] REG_IIR = 3'd2;
	localparam logic [2:0] REG_LCR = 3'd3;
	localparam logic [2:0] REG_MCR = 3'd4;
	localparam logic [2:0] REG_LSR = 3'd5;
	localparam logic [2:0] REG_MSR = 3'd6;
	localparam logic [2:0] REG_SCR = 3'd7;

	// Bit positions inside LCR and MCR.
	localparam int LCR_DLAB  = 7;
	localparam int LCR_BREAK = 6;
	localparam int MCR_LOOP  = 4;
	localparam int MCR_OUT2  = 3;

	// Interrupt identification codes, highest priority first.
	localparam logic [7:0] IIR_LINE  = 8'h06;
	localparam logic [7:0] IIR_RX    = 8'h04;
	localparam logic [7:0] IIR_THRE  = 8'h02;
	localparam logic [7:0] IIR_MODEM = 8'h00;
	localparam logic [7:0] IIR_NONE  = 8'h01;

	typedef struct packed {
		logic [7:0]  lcr;
		logic [3:0]  ier;
		logic [4:0]  mcr;
		logic [15:0] div;
		logic [7:0]  rbr;
		logic        dr;
		logic [3:0]  lerr;
		logic [7:0]  thr;
		logic        thr_empty;
		logic        shift_busy;
		logic [7:0]  shift_byte;
		logic        thre_pend;
		logic [3:0]  deltas;
		logic [3:0]  last_lines;
		logic [7:0]  scr;
	} state_t;

	localparam state_t STATE_RESET = '{
		lcr: 8'h00, ier: 4'h0, mcr: 5'h00, div: 16'h0000, rbr: 8'h00, dr: 1'b0,
		lerr: 4'h0, thr: 8'h00, thr_empty: 1'b1, shift_busy: 1'b0,
		shift_byte: 8'h00, thre_pend: 1'b0, deltas: 4'h0, last_lines: 4'h0,
		scr: 8'h00
	};

	typedef struct packed {
		op_t        op;
		logic [2:0] offset;
		logic [7:0] wdata;
		logic [7:0] rx_byte;
		logic [2:0] rx_errors;
		logic [3:0] lines;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_value;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        irq_out;
		logic [1:0]  modem_control;
		logic        break_out;
		logic [15:0] baud_divisor;
	} result_t;

	// Modem inputs as the status register sees them; loopback wires MCR back in.
	function automatic logic [3:0] eff_lines(input logic [4:0] mcr, input logic [3:0] lines);
		logic [3:0] r;
		if (mcr[MCR_LOOP]) begin
			r = {mcr[3], mcr[2], mcr[0], mcr[1]};
		end else begin
			r = lines;
		end
		return r;
	endfunction

	// CTS, DSR and DCD flag any change; RI flags only its trailing edge.
	function automatic logic [3:0] modem_delta(input logic [3:0] prev, input logic [3:0] now);
		logic [3:0] chg;
		chg = prev ^ now;
		return {chg[3], prev[2] & ~now[2], chg[1], chg[0]};
	endfunction

	function automatic logic [7:0] iir_code(input state_t s);
		logic [7:0] r;
		if (s.ier[2] && (s.lerr != 4'h0)) begin
			r = IIR_LINE;
		end else if (s.ier[0] && s.dr) begin
			r = IIR_RX;
		end else if (s.ier[1] && s.thre_pend) begin
			r = IIR_THRE;
		end else if (s.ier[3] && (s.deltas != 4'h0)) begin
			r = IIR_MODEM;
		end else begin
			r = IIR_NONE;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/uart_16550_register_model_unit.sv
// Top level of the FIFO-less 16550-style UART register block.
// Uses u16550_pkg, u16550_step and the assertion macro header.
//
// Usage:
// The input channel (in_valid / in_stall) carries one item per handshake: a
// bus read or write at offsets 0 to 7, a byte arriving from the serial line,
// or the transmitter reporting that its shifter has finished. The output
// channel (out_valid / out_stall) returns exactly one result item per input
// item, in order: the read data (zero unless a read), a transmit start with
// its byte, the gated interrupt line, DTR/RTS, break and the divisor latch.
// out_valid rises once an accepted item has moved from the input register into
// the result register; the register update and the result register load together.
// Throughput is one item per clock while out_stall is low; the read-modify-write
// of the register file in u16550_step is combinational.
// When the receiver stalls, the result register holds its item, the input
// register holds one more, and in_stall rises only while both are full.
// The register file advances only when a result is loaded, so the result
// register always matches the current register contents.
// Reset (arst_n low) clears every register to its power-on value, with the
// transmit holding register empty, and empties both pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_16550_register_model_unit_defines.svh"
module uart_16550_register_model_unit
	import u16550_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [2:0]  reg_offset,
	input  wire  [7:0]  write_value,
	input  wire  [7:0]  rx_byte,
	input  wire  [2:0]  rx_errors,
	input  wire  [3:0]  modem_lines,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [7:0]  read_value,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        irq_out,
	output logic [1:0]  modem_control,
	output logic        break_out,
	output logic [15:0] baud_divisor
);

	logic    valid_s1;
	item_t   item_s1;
	state_t  state_q;
	state_t  state_next;
	result_t res_next;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    accept;

	// Stage one moves forward whenever the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input register needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op        <= op_t'(operation);
			item_s1.offset    <= reg_offset;
			item_s1.wdata     <= write_value;
			item_s1.rx_byte   <= rx_byte;
			item_s1.rx_errors <= rx_errors;
			item_s1.lines     <= modem_lines;
		end
	end

	u16550_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next),
		.res  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = res_q.read_value;
	assign tx_valid      = res_q.tx_valid;
	assign tx_byte       = res_q.tx_byte;
	assign irq_out       = res_q.irq_out;
	assign modem_control = res_q.modem_control;
	assign break_out     = res_q.break_out;
	assign baud_divisor  = res_q.baud_divisor;

	// The input side is only held off while an item waits behind a stalled result.
	`U16550_ASSERT_IMP(a_stall_only_when_full, in_stall, valid_s1 && out_valid_q && out_stall, "in_stall without a full pipeline")
	// A started transmission leaves the shifter busy, which loopback never does.
	`U16550_ASSERT_IMP(a_tx_sets_busy, out_valid_q && tx_valid, state_q.shift_busy && !state_q.mcr[MCR_LOOP], "tx_valid without a busy shifter")
	// The interrupt line is gated by OUT2 of the register file behind the result.
	`U16550_ASSERT_IMP(a_irq_gated, out_valid_q && irq_out, state_q.mcr[MCR_OUT2], "irq_out with OUT2 clear")
	// A stalled result keeps the register file frozen.
	`U16550_ASSERT_NXT(a_state_frozen, out_valid_q && out_stall, state_q == $past(state_q), "register file moved under a stalled result")

endmodule
`default_nettype wire

>>> hdl/u16550_step.sv
// Next-state and result logic for one bus access or line event.
// Pure combinational; depends on u16550_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u16550_step
	import u16550_pkg::*;
(
	input  var state_t  cur,
	input  var item_t   item,
	output state_t      nxt,
	output result_t     res
);

	always_comb begin
		state_t     s;
		logic [3:0] eff_pre;
		logic [3:0] eff_post;
		logic [7:0] rd;
		logic [7:0] iir_pre;
		logic [7:0] iir_post;
		logic       dlab;
		logic       loop;
		logic       load;
		logic       txv;
		logic       rx_do;
		logic [7:0] rx_b;
		logic [2:0] rx_e;

		s     = cur;
		rd    = 8'h00;
		load  = 1'b0;
		txv   = 1'b0;
		rx_do = 1'b0;
		rx_b  = item.rx_byte;
		rx_e  = item.rx_errors;

		// Modem lines are sampled before the access so a status read sees them.
		eff_pre      = eff_lines(s.mcr, item.lines);
		s.deltas     = s.deltas | modem_delta(s.last_lines, eff_pre);
		s.last_lines = eff_pre;

		dlab    = s.lcr[LCR_DLAB];
		loop    = s.mcr[MCR_LOOP];
		iir_pre = iir_code(s);

		case (item.op)
			OP_READ: begin
				case (item.offset)
					REG_RBR: begin
						if (dlab) begin
							rd = s.div[7:0];
						end else begin
							rd   = s.rbr;
							s.dr = 1'b0;
						end
					end
					REG_IER: rd = dlab ? s.div[15:8] : {4'h0, s.ier};
					REG_IIR: begin
						rd = iir_pre;
						// Reporting the THR-empty cause acknowledges it.
						if (iir_pre == IIR_THRE) begin
							s.thre_pend = 1'b0;
						end
					end
					REG_LCR: rd = s.lcr;
					REG_MCR: rd = {3'b000, s.mcr};
					REG_LSR: begin
						rd     = {1'b0, s.thr_empty & ~s.shift_busy, s.thr_empty, s.lerr, s.dr};
						s.lerr = 4'h0;
					end
					REG_MSR: begin
						rd       = {eff_pre, s.deltas};
						s.deltas = 4'h0;
					end
					default: rd = s.scr;
				endcase
			end
			OP_WRITE: begin
				case (item.offset)
					REG_RBR: begin
						if (dlab) begin
							s.div[7:0] = item.wdata;
						end else begin
							s.thr         = item.wdata;
							s.thr_empty   = 1'b0;
							s.thre_pend   = 1'b0;
							load          = ~s.shift_busy;
						end
					end
					REG_IER: begin
						if (dlab) begin
							s.div[15:8] = item.wdata;
						end else begin
							if (item.wdata[1] && !s.ier[1] && s.thr_empty) begin
								s.thre_pend = 1'b1;
							end
							s.ier = item.wdata[3:0];
						end
					end
					REG_LCR: s.lcr = item.wdata;
					REG_MCR: s.mcr = item.wdata[4:0];
					REG_SCR: s.scr = item.wdata;
					default: ;
				endcase
			end
			OP_RX: rx_do = ~loop;
			OP_TX_DONE: begin
				if (s.shift_busy) begin
					s.shift_busy = 1'b0;
					load         = ~s.thr_empty;
				end
			end
			default: ;
		endcase

		// Holding register to shifter; in loopback the byte goes straight to RBR.
		if (load) begin
			s.thr_empty = 1'b1;
			s.thre_pend = 1'b1;
			if (loop) begin
				rx_do = 1'b1;
				rx_b  = s.thr;
				rx_e  = 3'b000;
			end else begin
				s.shift_byte = s.thr;
				s.shift_busy = 1'b1;
				txv          = 1'b1;
			end
		end

		if (rx_do) begin
			s.lerr = s.lerr | {rx_e, s.dr};
			s.rbr  = rx_b;
			s.dr   = 1'b1;
		end

		// Second sample catches loopback lines changed by an MCR write.
		eff_post     = eff_lines(s.mcr, item.lines);
		s.deltas     = s.deltas | modem_delta(s.last_lines, eff_post);
		s.last_lines = eff_post;

		iir_post = iir_code(s);

		nxt               = s;
		res.read_value    = rd;
		res.tx_valid      = txv;
		res.tx_byte       = txv ? s.shift_byte : 8'h00;
		res.irq_out       = (iir_post != IIR_NONE) && s.mcr[MCR_OUT2];
		res.modem_control = s.mcr[MCR_LOOP] ? 2'b00 : s.mcr[1:0];
		res.break_out     = s.lcr[LCR_BREAK];
		res.baud_divisor  = s.div;
	end

endmodule
`default_nettype wire
